### rtl/swizzled_texture_address_gen_defines.svh
// assertion macros shared by the checker of the swizzled texture address generator
// no dependencies; included by files that hold concurrent assertions
`ifndef SWIZZLED_TEXTURE_ADDRESS_GEN_DEFINES_SVH
`define SWIZZLED_TEXTURE_ADDRESS_GEN_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define STAG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stag check failed");

// next-cycle implication, disabled while rst is high
`define STAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stag check failed");

// next-cycle implication that also holds across reset
`define STAG_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stag check failed");

`endif

### rtl/stag_pkg.sv
// shared constants and types of the swizzled texture address generator
// no dependencies; used by the top level and the port checker
`default_nettype none

package stag_pkg;

   localparam int DEF_MAX_DIM_LOG2 = 12;
   localparam int CFG_W            = 13;
   localparam int OUT_W            = 26;
   localparam int CSR_IDX_W        = 2;

   localparam logic [31:0] EVEN_BITS = 32'h5555_5555;
   localparam logic [31:0] ODD_BITS  = 32'hAAAA_AAAA;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEX_WIDTH  = 2'd0,
      REG_TEX_HEIGHT = 2'd1,
      REG_ARGB_MODE  = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [OUT_W-1:0] src_offset;
      logic [OUT_W-1:0] dst_offset;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/swizzled_texture_address_gen.sv
// Z-order texture unswizzle address generator: one source/destination offset pair per step
// depends on stag_pkg
//
//   channel   ports                          direction   payload
//   req       req_valid / req_stall          in          restart
//   rsp       rsp_valid / rsp_stall          out         src_offset, dst_offset, last
//   csr       csr_we / csr_index             in          csr_wdata (13 bits)
//
// one step per cycle while req_stall is low: the offset adds feed the result register and the
// masked increments feed the position registers; a result is registered in the result register
// (or in the skid register while a result waits); this two-entry output buffer lets a transfer
// happen while a result waits; req_stall comes from the skid register alone
// reset clears position state, the registers (width 1, height 1, gray) and the valid flags of both buffer entries
`default_nettype none

module swizzled_texture_address_gen #(
   parameter int MAX_DIM_LOG2 = stag_pkg::DEF_MAX_DIM_LOG2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [stag_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [stag_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_restart,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [stag_pkg::OUT_W-1:0]     rsp_src_offset,
   output      logic [stag_pkg::OUT_W-1:0]     rsp_dst_offset,
   output      logic                           rsp_last
);

   localparam int OFS_W  = 2 * MAX_DIM_LOG2;
   localparam int CNT_W  = MAX_DIM_LOG2;
   localparam int DIM_W  = (stag_pkg::CFG_W > CNT_W + 1) ? stag_pkg::CFG_W : CNT_W + 1;
   localparam int LOG_W  = $clog2(MAX_DIM_LOG2 + 1);
   localparam int SH_W   = OFS_W + 2;
   localparam int WIDE_W = (SH_W > stag_pkg::OUT_W) ? SH_W : stag_pkg::OUT_W;
   localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(1) << MAX_DIM_LOG2;

   // configuration registers
   logic [stag_pkg::CFG_W-1:0] tex_width_ff, tex_height_ff;
   logic                       argb_mode_ff;

   // position state
   logic [OFS_W-1:0] col_offset_ff, col_offset_in;
   logic [OFS_W-1:0] row_base_ff, row_base_in;
   logic [OFS_W-1:0] col_start_ff, col_start_in;
   logic [OFS_W-1:0] linear_row_start_ff, linear_row_start_in;
   logic [CNT_W-1:0] col_count_ff, col_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;

   // output buffer
   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   stag_pkg::rsp_type rsp_data_ff, rsp_data_in;
   stag_pkg::rsp_type skid_data_ff, skid_data_in;
   stag_pkg::rsp_type step_result;

   // derived geometry
   logic [DIM_W-1:0] raw_w, raw_h, eff_w, eff_h;
   logic [LOG_W-1:0] log_w, log_h, log_min;
   logic [OFS_W-1:0] low_mask, xmask, ymask, tile;

   // step datapath
   logic [OFS_W-1:0] cur_col_offset, cur_row_base, cur_col_start, cur_linear;
   logic [CNT_W-1:0] cur_col_count, cur_row_count;
   logic [OFS_W-1:0] src_sum, dst_sum, row_base_step;
   logic [WIDE_W-1:0] src_wide, dst_wide;
   logic             row_end, frame_end;
   logic             req_xfer, rsp_xfer, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= stag_pkg::CFG_W'(1);
         tex_height_ff <= stag_pkg::CFG_W'(1);
         argb_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            stag_pkg::REG_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            stag_pkg::REG_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            stag_pkg::REG_ARGB_MODE:  argb_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      raw_w = DIM_W'(tex_width_ff);
      raw_h = DIM_W'(tex_height_ff);
      // zero acts as one, oversize saturates
      if (raw_w == '0) eff_w = DIM_W'(1);
      else if (raw_w > MAX_DIM) eff_w = MAX_DIM;
      else eff_w = raw_w;
      if (raw_h == '0) eff_h = DIM_W'(1);
      else if (raw_h > MAX_DIM) eff_h = MAX_DIM;
      else eff_h = raw_h;

      log_w = '0;
      log_h = '0;
      for (int i = 0; i < DIM_W; i++) begin
         if (eff_w[i]) log_w = LOG_W'(i);
         if (eff_h[i]) log_h = LOG_W'(i);
      end
      log_min = (log_w < log_h) ? log_w : log_h;

      // bits below the square tile size
      for (int i = 0; i < OFS_W; i++) begin
         low_mask[i] = ((LOG_W + 1)'(i) < {log_min, 1'b0});
      end
      xmask = stag_pkg::EVEN_BITS[OFS_W-1:0] | ~low_mask;
      ymask = stag_pkg::ODD_BITS[OFS_W-1:0] & low_mask;
      tile  = low_mask + OFS_W'(1);
   end

   always_comb begin
      if (req_restart) begin
         cur_col_offset = '0;
         cur_row_base   = '0;
         cur_col_start  = '0;
         cur_linear     = '0;
         cur_col_count  = '0;
         cur_row_count  = '0;
      end else begin
         cur_col_offset = col_offset_ff;
         cur_row_base   = row_base_ff;
         cur_col_start  = col_start_ff;
         cur_linear     = linear_row_start_ff;
         cur_col_count  = col_count_ff;
         cur_row_count  = row_count_ff;
      end

      row_end   = ({1'b0, DIM_W'(cur_col_count)} + (DIM_W + 1)'(1)) >= {1'b0, eff_w};
      frame_end = row_end
                  && (({1'b0, DIM_W'(cur_row_count)} + (DIM_W + 1)'(1)) >= {1'b0, eff_h});

      src_sum = cur_row_base + cur_col_offset;
      dst_sum = cur_linear + OFS_W'(cur_col_count);
      if (argb_mode_ff) begin
         src_wide = WIDE_W'({src_sum, 2'b00});
         dst_wide = WIDE_W'({dst_sum, 2'b00});
      end else begin
         src_wide = WIDE_W'(src_sum);
         dst_wide = WIDE_W'(dst_sum);
      end
      step_result.src_offset = src_wide[stag_pkg::OUT_W-1:0];
      step_result.dst_offset = dst_wide[stag_pkg::OUT_W-1:0];
      step_result.last       = frame_end;

      // y offset masked increment
      row_base_step = (cur_row_base - ymask) & ymask;

      col_offset_in       = cur_col_offset;
      row_base_in         = cur_row_base;
      col_start_in        = cur_col_start;
      linear_row_start_in = cur_linear;
      col_count_in        = cur_col_count;
      row_count_in        = cur_row_count;
      if (frame_end) begin
         col_offset_in       = '0;
         row_base_in         = '0;
         col_start_in        = '0;
         linear_row_start_in = '0;
         col_count_in        = '0;
         row_count_in        = '0;
      end else if (row_end) begin
         col_count_in        = '0;
         row_count_in        = cur_row_count + CNT_W'(1);
         linear_row_start_in = cur_linear + OFS_W'(eff_w);
         row_base_in         = row_base_step;
         // y wrapped: move on to the next square tile
         if (row_base_step == '0) col_start_in = cur_col_start + tile;
         col_offset_in       = (row_base_step == '0) ? cur_col_start + tile : cur_col_start;
      end else begin
         col_count_in  = cur_col_count + CNT_W'(1);
         col_offset_in = (cur_col_offset - xmask) & xmask;
      end
   end

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || rsp_xfer;

   always_comb begin
      rsp_valid_in  = !out_free || skid_valid_ff || req_xfer;
      skid_valid_in = skid_valid_ff ? !out_free : (req_xfer && !out_free);
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) rsp_data_in = skid_data_ff;
         else if (req_xfer) rsp_data_in = step_result;
      end else if (req_xfer) begin
         skid_data_in = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_offset_ff       <= '0;
         row_base_ff         <= '0;
         col_start_ff        <= '0;
         linear_row_start_ff <= '0;
         col_count_ff        <= '0;
         row_count_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         if (req_xfer) begin
            col_offset_ff       <= col_offset_in;
            row_base_ff         <= row_base_in;
            col_start_ff        <= col_start_in;
            linear_row_start_ff <= linear_row_start_in;
            col_count_ff        <= col_count_in;
            row_count_ff        <= row_count_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_src_offset = rsp_data_ff.src_offset;
   assign rsp_dst_offset = rsp_data_ff.dst_offset;
   assign rsp_last       = rsp_data_ff.last;

endmodule

`default_nettype wire

### rtl/stag_checker.sv
// port-level checker of the swizzled texture address generator, bound to the top level
// depends on stag_pkg, swizzled_texture_address_gen_defines.svh and the top level
`default_nettype none
`include "swizzled_texture_address_gen_defines.svh"

module stag_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           csr_we,
   input wire logic [stag_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [stag_pkg::CFG_W-1:0]     csr_wdata,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           req_restart,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [stag_pkg::OUT_W-1:0]     rsp_src_offset,
   input wire logic [stag_pkg::OUT_W-1:0]     rsp_dst_offset,
   input wire logic                           rsp_last
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // nothing left in the buffer after reset
   `STAG_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // input side only stalls while a result is held
   `STAG_ASSERT_NOW(a_stall_needs_result, clock, reset, !rsp_valid, !req_stall)

   // every input transfer shows a result on the next cycle
   `STAG_ASSERT_NEXT(a_xfer_gives_result, clock, reset, req_xfer, rsp_valid)

   // a stalled result holds
   `STAG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_src_offset) && $stable(rsp_dst_offset) && $stable(rsp_last))

endmodule

bind swizzled_texture_address_gen stag_checker u_stag_checker (.*);

`default_nettype wire
